FILE: rtl/windowed_average_heart_rate_macros.svh
// Assertion macros for the windowed average heart rate block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef WINDOWED_AVERAGE_HEART_RATE_MACROS_SVH
`define WINDOWED_AVERAGE_HEART_RATE_MACROS_SVH

// property checked at every edge out of reset
`define WAHR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent this edge, consequent at the next edge
`define WAHR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/wahr_pkg.sv
// Shared types and constants for the windowed average heart rate block.
// No dependencies.
package wahr_pkg;

	localparam int unsigned TS_W   = 32;
	localparam int unsigned RATE_W = 24;
	localparam int unsigned CNT_W  = 8;

	// 60000 ms per minute in Q8, also the saturation ceiling
	localparam logic [RATE_W-1:0] RATE_MAX = 24'd15360000;
	localparam logic [TS_W-1:0]   WINDOW_RESET = 32'd20000;

	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_WAITING   = 2'd1;
	localparam logic [1:0] PH_DONE      = 2'd2;
	localparam logic [1:0] PH_CANCELLED = 2'd3;

	localparam logic [1:0] MODE_BEAT   = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_RESET  = 2'd2;

	typedef struct packed {
		logic            done;
		logic [TS_W-1:0] quotient;
	} div_res_t;

endpackage

FILE: rtl/wahr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on wahr_pkg.
module wahr_div import wahr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [TS_W-1:0] dividend,
	input  logic [TS_W-1:0] divisor,
	output div_res_t        res
);

	localparam int unsigned CW = $clog2(TS_W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [TS_W-1:0] rem_q;
	logic [TS_W-1:0] quo_q;
	logic [TS_W-1:0] dsr_q;
	logic [TS_W:0]   trial;
	logic [TS_W:0]   diff;

	assign trial = {rem_q, quo_q[TS_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(TS_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out of the top of quo_q while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[TS_W]) begin
				rem_q <= diff[TS_W-1:0];
				quo_q <= {quo_q[TS_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[TS_W-1:0];
				quo_q <= {quo_q[TS_W-2:0], 1'b0};
			end
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

FILE: rtl/windowed_average_heart_rate.sv
// Windowed average heart rate: event sequencer, window state and result port.
// Depends on wahr_pkg and wahr_div.
//
// Input channel (in_valid/in_stall) carries one event per transaction: mode
// (beat, cancel, reset) and a wrapping millisecond timestamp. Each event gives
// exactly one result transaction on the output channel (out_valid/out_stall):
// phase, average bpm in unsigned Q8 (nonzero only when done) and interval count.
// cfg_write_en/cfg_write_data load the window length; write only when idle.
//
// One event at a time. Events that do not finalise pass from an evaluate state
// to the result state. A beat that closes the window with intervals recorded
// and a nonzero sum goes on through a multiply state to the restoring divider
// (one quotient bit a cycle) before the result state. in_stall stays high from
// acceptance until the result transaction completes, so no event is taken meanwhile.
// A stalled result holds its value until taken.
//
// arst_n clears the phase to idle, all window state to zero and the window
// length to 20000 ms. No clearing pass is needed.
module windowed_average_heart_rate import wahr_pkg::*; #(
	parameter int unsigned INTERVAL_CAP = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [TS_W-1:0]   cfg_write_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [TS_W-1:0]   timestamp_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [RATE_W-1:0] bpm_q8,
	output logic [CNT_W-1:0]  interval_total
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(INTERVAL_CAP);

	logic [2:0]        state_q;
	logic [1:0]        mode_q;
	logic [TS_W-1:0]   ts_q;
	logic [TS_W-1:0]   window_q;
	logic [1:0]        phase_q;
	logic [TS_W-1:0]   open_q;
	logic [TS_W-1:0]   prev_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TS_W-1:0]   sum_q;
	logic [RATE_W-1:0] rate_q;

	logic            accept;
	logic            expired;
	logic [TS_W-1:0] gap;
	logic [TS_W-1:0] numer;
	div_res_t        div_res;

	assign accept  = in_valid && !in_stall;
	// second expiry check in a beat uses the same timestamp, so one compare suffices
	assign expired = (ts_q - open_q) >= window_q;
	assign gap     = ts_q - prev_q;
	assign numer   = {{(TS_W-RATE_W){1'b0}}, RATE_MAX} * {{(TS_W-CNT_W){1'b0}}, cnt_q};

	wahr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_MUL),
		.dividend (numer),
		.divisor  (sum_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_write_en) begin
			window_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			ts_q   <= timestamp_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
			open_q  <= '0;
			prev_q  <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			rate_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_OUT;
					priority if (mode_q == MODE_BEAT) begin
						if (phase_q == PH_IDLE) begin
							open_q  <= ts_q;
							prev_q  <= ts_q;
							phase_q <= PH_WAITING;
						end else if (phase_q == PH_WAITING) begin
							if (expired) begin
								if (cnt_q == '0) begin
									rate_q  <= '0;
									phase_q <= PH_DONE;
								end else if (sum_q == '0) begin
									rate_q  <= RATE_MAX;
									phase_q <= PH_DONE;
								end else begin
									state_q <= S_MUL;
								end
							end else begin
								if (cnt_q < CAP) begin
									sum_q <= sum_q + gap;
									cnt_q <= cnt_q + 1'b1;
								end
								prev_q <= ts_q;
							end
						end
					end else if (mode_q == MODE_CANCEL) begin
						if (phase_q == PH_WAITING) phase_q <= PH_CANCELLED;
					end else if (mode_q == MODE_RESET) begin
						phase_q <= PH_IDLE;
						open_q  <= '0;
						prev_q  <= '0;
						cnt_q   <= '0;
						sum_q   <= '0;
						rate_q  <= '0;
					end else begin
						// unused mode: report state unchanged
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_res.done) begin
						rate_q  <= (div_res.quotient > {{(TS_W-RATE_W){1'b0}}, RATE_MAX}) ?
							RATE_MAX : div_res.quotient[RATE_W-1:0];
						phase_q <= PH_DONE;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != S_IDLE);
	assign out_valid      = (state_q == S_OUT);
	assign status         = phase_q;
	assign bpm_q8         = (phase_q == PH_DONE) ? rate_q : '0;
	assign interval_total = cnt_q;

endmodule

FILE: rtl/wahr_chk.sv
// Port-level checker for windowed_average_heart_rate, attached by bind.
// Depends on wahr_pkg and windowed_average_heart_rate_macros.svh.
`include "windowed_average_heart_rate_macros.svh"

module wahr_chk import wahr_pkg::*; #(
	parameter int unsigned INTERVAL_CAP = 128
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [1:0]        status,
	input logic [RATE_W-1:0] bpm_q8,
	input logic [CNT_W-1:0]  interval_total
);

	`WAHR_ASSERT(a_bpm_only_done, out_valid && (status != PH_DONE) |-> (bpm_q8 == '0), "bpm nonzero outside done")
	`WAHR_ASSERT(a_bpm_sat, out_valid |-> (bpm_q8 <= RATE_MAX), "bpm above saturation")
	`WAHR_ASSERT(a_cap, out_valid |-> (interval_total <= CNT_W'(INTERVAL_CAP)), "count above cap")
	`WAHR_ASSERT(a_one_at_a_time, out_valid |-> in_stall, "input taken while result pending")
	`WAHR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bpm_q8), "stalled result dropped")

endmodule

bind windowed_average_heart_rate wahr_chk #(.INTERVAL_CAP(INTERVAL_CAP)) u_wahr_chk (.*);

FILE: tb/wahr_result_checker.sv
`timescale 1ns / 1ps
// Result checker for windowed_average_heart_rate: follows the window state from
// accepted events and config writes, predicts each result and compares it. Uses wahr_pkg.
module wahr_result_checker import wahr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [TS_W-1:0]   cfg_write_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [TS_W-1:0]   timestamp_ms,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [RATE_W-1:0] bpm_q8,
	input  logic [CNT_W-1:0]  interval_total,
	input  logic              end_check,
	output int unsigned       fail_count,
	output int unsigned       pending_count
);

	localparam int unsigned INTERVAL_CAP = 128;
	localparam logic [63:0] MS_PER_MINUTE_Q8 = 64'd15360000;

	typedef struct packed {
		logic [1:0]        phase;
		logic [RATE_W-1:0] rate;
		logic [CNT_W-1:0]  intervals;
	} rate_result_t;

	rate_result_t      expected_rates[$];
	logic [TS_W-1:0]   window_len;
	logic [1:0]        phase;
	logic [TS_W-1:0]   open_time;
	logic [TS_W-1:0]   last_beat;
	logic [TS_W-1:0]   gap_sum;
	logic [CNT_W-1:0]  gap_count;
	logic [RATE_W-1:0] avg_rate;
	bit                leftovers_checked;

	task automatic report(input string what);
		fail_count++;
		$display("%0t ns: %s", $time, what);
	endtask

	function automatic void clear_window();
		phase     = PH_IDLE;
		open_time = '0;
		last_beat = '0;
		gap_sum   = '0;
		gap_count = '0;
		avg_rate  = '0;
	endfunction

	function automatic bit window_expired(input logic [TS_W-1:0] ts);
		logic [TS_W-1:0] age;
		age = ts - open_time;
		return age >= window_len;
	endfunction

	function automatic void close_window();
		logic [63:0] quo;
		if (gap_count == 0) begin
			avg_rate = '0;
		end else if (gap_sum == 0) begin
			avg_rate = RATE_MAX;
		end else begin
			quo = (MS_PER_MINUTE_Q8 * 64'(gap_count)) / 64'(gap_sum);
			avg_rate = (quo > 64'(RATE_MAX)) ? RATE_MAX : quo[RATE_W-1:0];
		end
		phase = PH_DONE;
	endfunction

	function automatic rate_result_t apply_event(input logic [1:0] m,
			input logic [TS_W-1:0] ts);
		rate_result_t r;
		case (m)
			MODE_BEAT: begin
				if (phase == PH_IDLE) begin
					open_time = ts;
					last_beat = ts;
					phase     = PH_WAITING;
				end else if (phase == PH_WAITING) begin
					if (window_expired(ts)) begin
						close_window();
					end else begin
						// past the cap the gap is dropped but the beat time still moves
						if (gap_count < INTERVAL_CAP) begin
							gap_sum   = gap_sum + (ts - last_beat);
							gap_count = gap_count + 1'b1;
						end
						last_beat = ts;
						if (window_expired(ts))
							close_window();
					end
				end
			end
			MODE_CANCEL: begin
				if (phase == PH_WAITING)
					phase = PH_CANCELLED;
			end
			MODE_RESET: clear_window();
			default: ;
		endcase
		r.phase     = phase;
		r.rate      = (phase == PH_DONE) ? avg_rate : '0;
		r.intervals = gap_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rate_result_t exp_r;
		if (!arst_n) begin
			clear_window();
			window_len = WINDOW_RESET;
			expected_rates.delete();
			fail_count = 0;
			pending_count = 0;
			leftovers_checked = 1'b0;
		end else begin
			if (cfg_write_en)
				window_len = cfg_write_data;
			if (out_valid && !out_stall) begin
				if (expected_rates.size() == 0) begin
					report($sformatf("unexpected result status=%0d bpm=%0d count=%0d",
						status, bpm_q8, interval_total));
				end else begin
					exp_r = expected_rates.pop_front();
					if (status !== exp_r.phase)
						report($sformatf("status got %0d expected %0d", status, exp_r.phase));
					if (bpm_q8 !== exp_r.rate)
						report($sformatf("bpm_q8 got %0d expected %0d", bpm_q8, exp_r.rate));
					if (interval_total !== exp_r.intervals)
						report($sformatf("interval_total got %0d expected %0d",
							interval_total, exp_r.intervals));
				end
			end
			if (in_valid && !in_stall)
				expected_rates.push_back(apply_event(mode, timestamp_ms));
			if (end_check && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (expected_rates.size() != 0)
					report($sformatf("%0d results never arrived", expected_rates.size()));
			end
			pending_count = expected_rates.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for windowed_average_heart_rate: clock, reset, event stimulus and verdict.
// Depends on wahr_pkg, the block and wahr_result_checker.
module tb_top;
	import wahr_pkg::*;

	localparam logic [1:0] MODE_IGNORED = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              cfg_write_en;
	logic [TS_W-1:0]   cfg_write_data;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        mode;
	logic [TS_W-1:0]   timestamp_ms;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [RATE_W-1:0] bpm_q8;
	logic [CNT_W-1:0]  interval_total;
	logic              end_check;
	int unsigned       fail_count;
	int unsigned       pending_count;

	int unsigned       events_sent;
	int unsigned       tx_idle_pct;
	int unsigned       rx_idle_pct;
	int                hold_cycles;
	logic [TS_W-1:0]   window_ms;

	windowed_average_heart_rate i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.timestamp_ms   (timestamp_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.bpm_q8         (bpm_q8),
		.interval_total (interval_total)
	);

	wahr_result_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.timestamp_ms   (timestamp_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.bpm_q8         (bpm_q8),
		.interval_total (interval_total),
		.end_check      (end_check),
		.fail_count     (fail_count),
		.pending_count  (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random stall, or a long hold-off when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("** windowed_average_heart_rate: FAILED **");
		$finish;
	end

	// one event transaction; valid stays high afterwards unless the next call idles or quiesces
	task automatic send_event(input logic [1:0] m, input logic [TS_W-1:0] ts);
		@(negedge clk);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		timestamp_ms <= ts;
		do @(posedge clk); while (in_stall);
		events_sent++;
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	task automatic write_window(input logic [TS_W-1:0] value);
		quiesce();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(negedge clk);
		cfg_write_en   <= 1'b0;
		window_ms = value;
	endtask

	// one measurement: optional reset, opening beat, beats with random gaps mixed with
	// cancel and unused-mode events, an optional closing beat and some optional events afterwards
	task automatic run_session();
		logic [TS_W-1:0] t;
		logic [TS_W-1:0] open_t;
		logic [TS_W-1:0] step_max;
		logic [TS_W-1:0] step;
		int              beats;
		bit              cap_run;
		int unsigned     pick;
		if ($urandom_range(0, 9) < 8)
			send_event(MODE_RESET, $urandom());
		t = ($urandom_range(0, 3) == 0) ? (32'hFFFF_FFFF - $urandom_range(0, 2000)) : $urandom();
		open_t = t;
		send_event(MODE_BEAT, t);
		cap_run  = ($urandom_range(0, 19) == 0);
		beats    = cap_run ? $urandom_range(130, 140) : $urandom_range(0, 10);
		step_max = cap_run ? window_ms / 300 : window_ms / 3;
		for (int i = 0; i < beats; i++) begin
			pick = $urandom_range(0, 99);
			if (!cap_run && pick < 4) begin
				send_event(MODE_CANCEL, $urandom());
			end else if (!cap_run && pick < 7) begin
				send_event(MODE_IGNORED, $urandom());
			end else begin
				if (cap_run)
					step = $urandom_range(0, step_max);
				else if (pick < 15)
					step = '0;
				else if (pick < 22)
					step = $urandom();
				else
					step = $urandom_range(0, step_max);
				t = t + step;
				send_event(MODE_BEAT, t);
			end
		end
		if ($urandom_range(0, 4) != 0)
			send_event(MODE_BEAT, open_t + window_ms + $urandom_range(0, 50));
		if ($urandom_range(0, 2) == 0)
			send_event(MODE_BEAT, $urandom());
		if ($urandom_range(0, 4) == 0)
			send_event(MODE_CANCEL, $urandom());
	endtask

	initial begin
		logic [TS_W-1:0] windows[6];
		int unsigned     budget;
		bit              held;
		arst_n         = 1'b0;
		cfg_write_en   = 1'b0;
		cfg_write_data = '0;
		in_valid       = 1'b0;
		mode           = MODE_BEAT;
		timestamp_ms   = '0;
		end_check      = 1'b0;
		events_sent    = 0;
		tx_idle_pct    = 38;
		rx_idle_pct    = 67;
		hold_cycles    = 0;
		window_ms      = WINDOW_RESET;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, with the window at its reset value
		send_event(MODE_BEAT, 32'hFFFF_FFF0);
		send_event(MODE_BEAT, 32'h0000_0010);   // gap wraps through zero
		send_event(MODE_BEAT, 32'h0000_4E10);   // window expires
		send_event(MODE_BEAT, 32'd5);           // ignored when done
		send_event(MODE_CANCEL, 32'hFFFF_FFFF);
		send_event(MODE_IGNORED, 32'hFFFF_FFFF);
		send_event(MODE_RESET, 32'hAAAA_5555);
		send_event(MODE_CANCEL, 32'h5555_AAAA); // ignored when idle
		send_event(MODE_BEAT, 32'd0);
		send_event(MODE_BEAT, 32'd1000);
		send_event(MODE_CANCEL, 32'd0);
		send_event(MODE_BEAT, 32'd2000);        // ignored when cancelled
		send_event(MODE_RESET, 32'd0);
		send_event(MODE_BEAT, 32'd5);
		send_event(MODE_BEAT, 32'd20005);       // no interval recorded
		send_event(MODE_RESET, 32'd0);
		send_event(MODE_BEAT, 32'd100);
		send_event(MODE_BEAT, 32'd100);
		send_event(MODE_BEAT, 32'd100);
		send_event(MODE_BEAT, 32'd30000);       // zero sum saturates
		send_event(MODE_RESET, 32'd0);
		send_event(MODE_BEAT, 32'd7);
		send_event(MODE_BEAT, 32'd7);
		send_event(MODE_BEAT, 32'd8);
		send_event(MODE_BEAT, 32'd20007);       // quotient above ceiling

		windows[0] = 32'd1;
		windows[1] = 32'hFFFF_FFFF;
		windows[2] = $urandom_range(2, 400);
		windows[3] = $urandom_range(1, 32'hFFFF_FFFF);
		windows[4] = WINDOW_RESET;
		windows[5] = $urandom_range(1000, 100000);
		for (int p = 0; p < 6; p++) begin
			write_window(windows[p]);
			tx_idle_pct = (p < 2) ? 38 : (p < 4) ? 67 : 0;
			rx_idle_pct = (p < 2) ? 67 : (p < 4) ? 38 : 0;
			budget = events_sent + 220;
			held   = 1'b0;
			while (events_sent < budget) begin
				// receiver holds off while events keep coming, so the input backs up
				if ((p == 0 || p == 4) && !held && events_sent + 150 < budget) begin
					hold_cycles = 400;
					held = 1'b1;
				end
				run_session();
			end
		end

		quiesce();
		repeat (40) @(negedge clk);
		end_check <= 1'b1;
		@(negedge clk);
		if (fail_count == 0)
			$display("** windowed_average_heart_rate: PASSED **");
		else
			$display("** windowed_average_heart_rate: FAILED **");
		$finish;
	end

endmodule
